// ===== src/qpe_pkg.sv =====
// qpe_pkg: shared types and constants of the qoi pixel encoder
// used by qpe_front, qpe_queue, qpe_back and qoi_pixel_encoder
package qpe_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [5:0]  RUN_CAP     = 6'd62;
    localparam logic [7:0]  TAG_RUN     = 8'hC0;
    localparam logic [7:0]  TAG_DIFF    = 8'h40;
    localparam logic [7:0]  TAG_LUMA    = 8'h80;
    localparam logic [7:0]  TAG_RGB     = 8'hFE;
    localparam logic [7:0]  TAG_RGBA    = 8'hFF;
    localparam logic [31:0] PREV_RESET  = 32'h0000_00FF;
    localparam logic [2:0]  CHAN_RESET  = 3'd4;
    localparam logic [2:0]  CHAN_RGB    = 3'd3;

    localparam logic [7:0] END_MARKER [8] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INDEX,
        OP_DIFF,
        OP_LUMA,
        OP_RGB,
        OP_RGBA
    } t_op;

    typedef struct packed {
        logic       has_run;
        logic [5:0] run_code;
        t_op        op;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_cmd;

    function automatic logic [2:0] op_len(input t_op op);
        logic [2:0] len;
        case (op)
            OP_INDEX: len = 3'd1;
            OP_DIFF:  len = 3'd1;
            OP_LUMA:  len = 3'd2;
            OP_RGB:   len = 3'd4;
            OP_RGBA:  len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/qpe_front.sv =====
// qpe_front: accepts pixels, holds previous pixel, run count and color index
// classifies each pixel into a byte request for the queue; depends on qpe_pkg
module qpe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_alpha,
    input  logic          i_last_pixel,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_data,
    output logic          o_push,
    input  logic          i_push_ready,
    output qpe_pkg::t_cmd o_cmd
);
    import qpe_pkg::*;

    logic [2:0]  r_chan;
    logic        r_a_valid;
    logic [7:0]  r_a_red, r_a_green, r_a_blue, r_a_alpha;
    logic        r_a_last;
    logic [5:0]  r_a_pos;
    logic [31:0] r_prev, n_prev;
    logic [5:0]  r_run, n_run;
    logic [63:0] r_idx_valid;
    logic [31:0] r_mem [64];
    logic [31:0] r_rd_data;
    logic        r_fwd;
    logic [31:0] r_fwd_data;

    logic        accept, fire, same, hit, emit, we;
    logic [7:0]  in_alpha;
    logic [5:0]  in_pos, run_inc;
    logic [31:0] px, entry;
    logic [7:0]  vr, vg, vb, vgr, vgb;
    logic [7:0]  diff_r, diff_g, diff_b, luma_g, luma_r, luma_b;
    logic        small_diff, luma_ok;
    t_cmd        cmd;

    assign in_alpha = (r_chan == CHAN_RGB) ? 8'hFF : i_alpha;
    assign in_pos   = i_red[5:0] * 6'd3 + i_green[5:0] * 6'd5
                    + i_blue[5:0] * 6'd7 + in_alpha[5:0] * 6'd11;

    assign px      = {r_a_red, r_a_green, r_a_blue, r_a_alpha};
    assign same    = (px == r_prev);
    assign run_inc = r_run + 6'd1;
    assign entry   = r_idx_valid[r_a_pos] ? (r_fwd ? r_fwd_data : r_rd_data) : 32'h0;
    assign hit     = (entry == px);

    assign vr  = r_a_red   - r_prev[31:24];
    assign vg  = r_a_green - r_prev[23:16];
    assign vb  = r_a_blue  - r_prev[15:8];
    assign vgr = vr - vg;
    assign vgb = vb - vg;

    // offset by bias so the signed ranges become unsigned compares
    assign diff_r = vr + 8'd2;
    assign diff_g = vg + 8'd2;
    assign diff_b = vb + 8'd2;
    assign luma_g = vg + 8'd32;
    assign luma_r = vgr + 8'd8;
    assign luma_b = vgb + 8'd8;

    assign small_diff = (diff_r < 8'd4) && (diff_g < 8'd4) && (diff_b < 8'd4);
    assign luma_ok    = (luma_g < 8'd64) && (luma_r < 8'd16) && (luma_b < 8'd16);

    always_comb begin
        cmd          = '0;
        cmd.red      = r_a_red;
        cmd.green    = r_a_green;
        cmd.blue     = r_a_blue;
        cmd.alpha    = r_a_alpha;
        cmd.last     = r_a_last;
        cmd.op       = OP_NONE;
        n_run        = 6'd0;
        if (same) begin
            if (run_inc == RUN_CAP || r_a_last) begin
                cmd.has_run  = 1'b1;
                cmd.run_code = r_run;
            end else begin
                n_run = run_inc;
            end
        end else begin
            cmd.has_run  = (r_run != 6'd0);
            cmd.run_code = r_run - 6'd1;
            if (hit) begin
                cmd.op = OP_INDEX;
                cmd.b0 = {2'b00, r_a_pos};
            end else if (r_a_alpha == r_prev[7:0]) begin
                if (small_diff) begin
                    cmd.op = OP_DIFF;
                    cmd.b0 = TAG_DIFF | {2'b00, diff_r[1:0], diff_g[1:0], diff_b[1:0]};
                end else if (luma_ok) begin
                    cmd.op = OP_LUMA;
                    cmd.b0 = TAG_LUMA | {2'b00, luma_g[5:0]};
                    cmd.b1 = {luma_r[3:0], luma_b[3:0]};
                end else begin
                    cmd.op = OP_RGB;
                    cmd.b0 = TAG_RGB;
                end
            end else begin
                cmd.op = OP_RGBA;
                cmd.b0 = TAG_RGBA;
            end
        end
        if (r_a_last) begin
            n_run  = 6'd0;
            n_prev = PREV_RESET;
        end else begin
            n_prev = px;
        end
    end

    assign emit    = cmd.has_run || (cmd.op != OP_NONE) || r_a_last;
    assign fire    = r_a_valid && (!emit || i_push_ready);
    assign o_stall = r_a_valid && !fire;
    assign accept  = i_valid && !o_stall;
    assign we      = fire && !same;
    assign o_push  = r_a_valid && emit;
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan      <= CHAN_RESET;
            r_a_valid   <= 1'b0;
            r_prev      <= PREV_RESET;
            r_run       <= 6'd0;
            r_idx_valid <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_chan <= i_cfg_data;
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (fire) begin
                r_a_valid <= 1'b0;
            end
            if (fire) begin
                r_prev <= n_prev;
                r_run  <= n_run;
                if (r_a_last) begin
                    r_idx_valid <= '0;
                end else if (we) begin
                    r_idx_valid[r_a_pos] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_red    <= i_red;
            r_a_green  <= i_green;
            r_a_blue   <= i_blue;
            r_a_alpha  <= in_alpha;
            r_a_last   <= i_last_pixel;
            r_a_pos    <= in_pos;
            r_rd_data  <= r_mem[in_pos];
            r_fwd      <= we && (r_a_pos == in_pos);
            r_fwd_data <= px;
        end
        if (we) begin
            r_mem[r_a_pos] <= px;
        end
    end

endmodule

// ===== src/qpe_queue.sv =====
// qpe_queue: short request queue between front and back of the encoder
// depends on qpe_pkg for the request type and depth
module qpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_push_ready,
    input  qpe_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_pop,
    output qpe_pkg::t_cmd o_cmd
);
    import qpe_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push, pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_cmd        = r_slot[r_rd_ptr];
    assign push         = i_push && o_push_ready;
    assign pop          = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/qpe_back.sv =====
// qpe_back: walks one queued request into code bytes, one byte per cycle while
// the output is not stalled; holds the output register; depends on qpe_pkg
module qpe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  qpe_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_code_byte,
    output logic          o_last_of_pixel,
    output logic          o_end_of_stream
);
    import qpe_pkg::*;

    logic [3:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_lop, r_eos;

    logic       load, final_byte;
    logic [2:0] len;
    logic [3:0] total, jr, mk;
    logic [7:0] cur_byte;

    assign len        = op_len(i_cmd.op);
    assign total      = {3'b000, i_cmd.has_run} + {1'b0, len} + (i_cmd.last ? 4'd8 : 4'd0);
    assign jr         = r_idx - {3'b000, i_cmd.has_run};
    assign mk         = jr - {1'b0, len};
    assign final_byte = (r_idx == total - 4'd1);
    assign load       = i_cmd_valid && (!r_valid || !i_stall);
    assign o_pop      = load && final_byte;

    always_comb begin
        if (i_cmd.has_run && r_idx == 4'd0) begin
            cur_byte = TAG_RUN | {2'b00, i_cmd.run_code};
        end else if (jr < {1'b0, len}) begin
            case (jr[2:0])
                3'd0:    cur_byte = i_cmd.b0;
                3'd1:    cur_byte = (i_cmd.op == OP_LUMA) ? i_cmd.b1 : i_cmd.red;
                3'd2:    cur_byte = i_cmd.green;
                3'd3:    cur_byte = i_cmd.blue;
                3'd4:    cur_byte = i_cmd.alpha;
                default: cur_byte = 8'h00;
            endcase
        end else begin
            cur_byte = END_MARKER[mk[2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && i_stall);
            if (load) begin
                r_idx <= final_byte ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_lop  <= final_byte;
            r_eos  <= final_byte && i_cmd.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_code_byte     = r_byte;
    assign o_last_of_pixel = r_lop;
    assign o_end_of_stream = r_eos;

endmodule

// ===== src/qoi_pixel_encoder.sv =====
// qoi_pixel_encoder: top level, front classifier, request queue, byte back end
// depends on qpe_pkg, qpe_front, qpe_queue, qpe_back
//
//  channel   handshake              payload
//  pixel in  i_valid / o_stall      i_red i_green i_blue i_alpha i_last_pixel
//  bytes out o_valid / i_stall      o_code_byte o_last_of_pixel o_end_of_stream
//  config    i_cfg_valid / o_cfg_ready  i_cfg_data (channel count)
//
// a pixel is taken every cycle while the four-entry queue has room; the front
// reads the color index at accept and classifies in the next cycle, so the first
// byte of a pixel then passes a queue slot and the output register on its way out
// the back end sends one byte per cycle while the output is not stalled, so a
// pixel costs 0 to 14 bytes and the byte count sets the sustained rate
// synchronous active-low reset clears the color index valid bits at once
// either side may stall; the queue and the output register absorb it
module qoi_pixel_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    input  logic       i_last_pixel,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_pixel,
    output logic       o_end_of_stream,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);
    import qpe_pkg::*;

    logic push, push_ready, q_valid, pop;
    t_cmd f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    qpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_alpha      (i_alpha),
        .i_last_pixel (i_last_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_cmd        (f_cmd)
    );

    qpe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_cmd        (f_cmd),
        .o_valid      (q_valid),
        .i_pop        (pop),
        .o_cmd        (q_cmd)
    );

    qpe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_byte     (o_code_byte),
        .o_last_of_pixel (o_last_of_pixel),
        .o_end_of_stream (o_end_of_stream)
    );

endmodule
